// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg: shared types and constants of the serial frame receiver
// Holds the beat payloads, the receiver state codes, the beat kinds and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // buffer and framing constants
  localparam int unsigned SFR_BUFFER_DEPTH = 128;
  localparam logic [7:0] START_BYTE = 8'h7A;
  localparam logic [7:0] END_BYTE   = 8'h7F;
  localparam logic [7:0] HMI_MARK   = 8'hFF;
  localparam int unsigned HMI_GROUP_LEN = 4;

  // configuration reset values
  localparam logic [7:0] MIN_LENGTH_RST = 8'd10;
  localparam logic [7:0] MAX_LENGTH_RST = 8'd100;
  localparam logic [7:0] LENGTH_FLOOR   = 8'd2;

  // receiver state codes
  typedef enum logic [1:0] {
    ST_WAIT = 2'd0,
    ST_READ = 2'd1,
    ST_PEND = 2'd2
  } rx_state_e;

  // beat kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_LENGTH = 2'd0,
    CFG_MAX_LENGTH = 2'd1,
    CFG_HMI_MODE   = 2'd2
  } cfg_idx_e;

  // input beat payload
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [6:0] read_index;
  } in_beat_t;

  // result beat payload
  typedef struct packed {
    logic [1:0] receiver_state;
    logic       frame_ready;
    logic       frame_error;
    logic [7:0] frame_length;
    logic       hmi_reply_valid;
    logic [7:0] hmi_reply_code;
    logic       restart_timeout;
    logic [7:0] read_data;
  } out_beat_t;

endpackage

// File: rtl/sfr_if.sv
// ----------------------------------------------------------------------------
// sfr_if: valid/ready channels of the serial frame receiver
// One interface for the input beats and one for the result beats.
// ----------------------------------------------------------------------------
interface sfr_in_if;
  logic             valid;
  logic             ready;
  sfr_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sfr_out_if;
  logic              valid;
  logic              ready;
  sfr_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/serial_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit: start/length/end byte frame receiver
// Frames open on a start byte, take their length from the second byte and
// close on an end byte; an optional HMI mode collects four-byte replies.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  in_i      in   valid/ready     kind, byte_value, read_index
//  res_o     out  valid/ready     receiver state, pulses, length, reply, read data
//  cfg_*     in   cfg_we_i only   min_length, max_length, hmi_mode
//
//  One beat per cycle sustained while res_o is ready; every input beat gives
//  one result beat through the stage one and result registers: the state
//  update and buffer write are done in the accept cycle, the buffer read data
//  comes from the RAM's registered port. The result register and the stage
//  before it let one more beat in while a result waits. Reset clears the
//  buffer at once through per-entry valid bits, so no clearing pass is needed
//  and a beat is taken right after reset.
module serial_frame_receiver_unit #(
  parameter int unsigned BUFFER_DEPTH = sfr_pkg::SFR_BUFFER_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  sfr_in_if.sink     in_i,
  sfr_out_if.source  res_o
);

  localparam int unsigned AW   = $clog2(BUFFER_DEPTH);
  localparam int unsigned WP_W = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned CW   = ((WP_W > 8) ? WP_W : 8) + 1;
  localparam int unsigned HP_W = $clog2(sfr_pkg::HMI_GROUP_LEN);

  localparam logic [CW-1:0] DEPTH_X = CW'(BUFFER_DEPTH);

  // stage one: result without read data, plus read qualifier
  typedef struct packed {
    sfr_pkg::out_beat_t res;
    logic               rd_ok;
  } s1_t;

  // configuration registers
  logic [7:0] min_len_q, max_len_q;
  logic       hmi_mode_q;

  // receiver state
  sfr_pkg::rx_state_e rx_state_q, rx_state_d;
  logic [WP_W-1:0]    wp_q, wp_d;
  logic [7:0]         len_q, len_d;
  logic [BUFFER_DEPTH-1:0] vld_q, vld_d;
  logic [7:0]         hmi_q [sfr_pkg::HMI_GROUP_LEN];
  logic [7:0]         hmi_d [sfr_pkg::HMI_GROUP_LEN];
  logic [HP_W-1:0]    hpos_q, hpos_d;

  // pipeline
  logic s1_vld_q, s2_vld_q;
  s1_t  s1_q, s1_d;
  sfr_pkg::out_beat_t s2_q, s2_d;
  logic in_fire, s1_adv;
  logic [7:0] ram_rdata;

  // decoded events of the accepted beat
  sfr_pkg::in_beat_t beat;
  logic       clr, err, rdy, hvalid, restart;
  logic [7:0] hcode;
  logic       wr_en;
  logic [AW-1:0] waddr, raddr;
  logic       rd_ok;

  assign beat = in_i.data;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q  <= sfr_pkg::MIN_LENGTH_RST;
      max_len_q  <= sfr_pkg::MAX_LENGTH_RST;
      hmi_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfr_pkg::CFG_MIN_LENGTH: min_len_q  <= cfg_data_i;
        sfr_pkg::CFG_MAX_LENGTH: max_len_q  <= cfg_data_i;
        sfr_pkg::CFG_HMI_MODE:   hmi_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // handshake: stage one drains into the result register
  assign s1_adv     = s1_vld_q && (!s2_vld_q || res_o.ready);
  assign in_i.ready = !s1_vld_q || s1_adv;
  assign in_fire    = in_i.valid && in_i.ready;

  // event decode and datapath next values
  always_comb begin
    logic [CW-1:0]   b_x, len_x, wp_x, inc_x;
    logic [WP_W-1:0] wp_inc;
    b_x     = CW'(beat.byte_value);
    len_x   = CW'(len_q);
    wp_x    = CW'(wp_q);
    wp_inc  = wp_q + WP_W'(1);
    inc_x   = CW'(wp_inc);
    clr     = 1'b0;
    err     = 1'b0;
    rdy     = 1'b0;
    hvalid  = 1'b0;
    hcode   = 8'd0;
    restart = 1'b0;
    wr_en   = 1'b0;
    waddr   = '0;
    wp_d    = wp_q;
    len_d   = len_q;
    hpos_d  = hpos_q;
    hmi_d   = hmi_q;
    unique case (sfr_pkg::kind_e'(beat.kind))
      sfr_pkg::KIND_BYTE: begin
        unique case (rx_state_q)
          sfr_pkg::ST_WAIT: begin
            wr_en = 1'b1;
            if (beat.byte_value == sfr_pkg::START_BYTE) begin
              wp_d = WP_W'(1);
            end else begin
              wp_d = '0;
              // HMI reply collection
              if (hmi_mode_q) begin
                restart        = 1'b1;
                hmi_d[hpos_q]  = beat.byte_value;
                hpos_d         = hpos_q + HP_W'(1);
                if (hpos_q == HP_W'(sfr_pkg::HMI_GROUP_LEN - 1)) begin
                  if (hmi_q[1] == sfr_pkg::HMI_MARK && hmi_q[2] == sfr_pkg::HMI_MARK &&
                      beat.byte_value == sfr_pkg::HMI_MARK) begin
                    hvalid = 1'b1;
                    hcode  = hmi_q[0];
                  end
                  for (int i = 0; i < sfr_pkg::HMI_GROUP_LEN; i++) begin
                    hmi_d[i] = 8'd0;
                  end
                  hpos_d = '0;
                end
              end
            end
          end
          sfr_pkg::ST_READ: begin
            restart = 1'b1;
            wr_en   = (wp_x < DEPTH_X);
            waddr   = wp_q[AW-1:0];
            if (wp_q == WP_W'(1)) begin
              // length byte
              len_d = beat.byte_value;
              if (beat.byte_value > max_len_q || beat.byte_value < min_len_q ||
                  beat.byte_value < sfr_pkg::LENGTH_FLOOR || b_x > DEPTH_X) begin
                clr = 1'b1;
                err = 1'b1;
              end else begin
                wp_d = WP_W'(2);
              end
            end else if (wp_x + CW'(1) == len_x) begin
              // last index: end byte check
              if (beat.byte_value == sfr_pkg::END_BYTE) begin
                rdy = 1'b1;
              end else begin
                clr = 1'b1;
                err = 1'b1;
              end
            end else begin
              wp_d = wp_inc;
              if (inc_x + CW'(1) > len_x || inc_x >= DEPTH_X) begin
                clr = 1'b1;
                err = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
      sfr_pkg::KIND_CLEAR: clr = 1'b1;
      default: ;
    endcase
    if (clr) begin
      wp_d  = '0;
      len_d = 8'd0;
    end
    if (!in_fire) begin
      wr_en  = 1'b0;
      wp_d   = wp_q;
      len_d  = len_q;
      hpos_d = hpos_q;
      hmi_d  = hmi_q;
    end
  end

  // next receiver state
  always_comb begin
    rx_state_d = rx_state_q;
    if (in_fire) begin
      if (clr) begin
        rx_state_d = sfr_pkg::ST_WAIT;
      end else if (rdy) begin
        rx_state_d = sfr_pkg::ST_PEND;
      end else if (beat.kind == sfr_pkg::KIND_BYTE && rx_state_q == sfr_pkg::ST_WAIT &&
                   beat.byte_value == sfr_pkg::START_BYTE) begin
        rx_state_d = sfr_pkg::ST_READ;
      end
    end
  end

  // buffer valid bits: cleared together, set on write
  always_comb begin
    vld_d = vld_q;
    if (in_fire && clr) begin
      vld_d = '0;
    end else if (wr_en) begin
      vld_d[waddr] = 1'b1;
    end
  end

  // read qualifier: in range and written since the last clear
  assign raddr = AW'(beat.read_index);
  assign rd_ok = (beat.kind == sfr_pkg::KIND_READ) &&
                 (CW'(beat.read_index) < DEPTH_X) && vld_q[raddr];

  // result fields of stage one
  always_comb begin
    s1_d.res.receiver_state  = rx_state_d;
    s1_d.res.frame_ready     = rdy;
    s1_d.res.frame_error     = err;
    s1_d.res.frame_length    = len_d;
    s1_d.res.hmi_reply_valid = hvalid;
    s1_d.res.hmi_reply_code  = hcode;
    s1_d.res.restart_timeout = restart;
    s1_d.res.read_data       = 8'd0;
    s1_d.rd_ok               = rd_ok;
  end

  // frame buffer
  sfr_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (beat.byte_value),
    .re_i    (in_fire),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // receiver state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_state_q <= sfr_pkg::ST_WAIT;
      wp_q       <= '0;
      len_q      <= 8'd0;
      vld_q      <= '0;
      hpos_q     <= '0;
      for (int i = 0; i < sfr_pkg::HMI_GROUP_LEN; i++) begin
        hmi_q[i] <= 8'd0;
      end
    end else begin
      rx_state_q <= rx_state_d;
      wp_q       <= wp_d;
      len_q      <= len_d;
      vld_q      <= vld_d;
      hpos_q     <= hpos_d;
      hmi_q      <= hmi_d;
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      if (!s2_vld_q || res_o.ready) begin
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  // result register input: read data joins the stage one fields
  always_comb begin
    s2_d           = s1_q.res;
    s2_d.read_data = s1_q.rd_ok ? ram_rdata : 8'd0;
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      s2_q <= s2_d;
    end
  end

  assign res_o.valid = s2_vld_q;
  assign res_o.data  = s2_q;

  // a frame never both completes and fails
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !(rdy && err))
    else $error("frame ready and frame error in one beat");

  // waiting always leaves the write position at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_state_q == sfr_pkg::ST_WAIT |-> wp_q == '0)
    else $error("write position not zero while waiting");

  // reading keeps the write position inside the buffer and past the start byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_state_q == sfr_pkg::ST_READ |-> (wp_q != '0) && (CW'(wp_q) < DEPTH_X))
    else $error("write position out of range while reading");

  // an HMI reply only comes in HMI mode, and its code only with the pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (hvalid || hcode != 8'd0) |-> hvalid && hmi_mode_q)
    else $error("HMI reply outside HMI mode");

  // a clear leaves no written buffer entry behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && clr |=> vld_q == '0)
    else $error("buffer entries survive a clear");

endmodule

// File: rtl/sfr_ram.sv
// ----------------------------------------------------------------------------
// sfr_ram: generic single-port-write, registered-read RAM
// One write port and one read port; read data is registered on read enable.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
